>>> design/lobm_pkg.sv
// Shared constants, types and controller states of the order book matcher.
package lobm_pkg;

    localparam int BOOK_DEPTH = 1024;
    localparam int ADDR_W     = $clog2(BOOK_DEPTH);
    localparam int CNT_W      = $clog2(BOOK_DEPTH + 1);
    localparam int FIELD_W    = 30;
    localparam int ENTRY_W    = 2 * FIELD_W;

    localparam logic [FIELD_W-1:0] BACKLOG_MOD = 30'd1000000007;

    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN_START,
        ST_SCAN,
        ST_DECIDE,
        ST_LAST_WAIT,
        ST_MOVE,
        ST_TOTAL,
        ST_APPEND,
        ST_DONE
    } lobm_state_t;

    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan;
        logic take;
        logic move;
        logic total;
        logic append;
    } lobm_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic limit_ok;
        logic partial;
        logic rest_zero;
        logic opp_empty;
    } lobm_status_t;

endpackage

>>> design/limit_order_book_matcher.sv
// Each scan of the opposite book reads it linearly through the single-read-port book memory,
// so the time an order takes grows with the opposite book's size at each scan and with the
// number of entries used up.
// Throughput: one order at a time; busy stays high until the done cycle ends.
// Results appear for one cycle on done; the receiver cannot stall.
// Reset (rst_n, async, active low) empties both books and clears the total.
module limit_order_book_matcher
    import lobm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               func,
    input  logic [FIELD_W-1:0] price,
    input  logic [FIELD_W-1:0] amount_in,
    output logic               done,
    output logic [FIELD_W-1:0] backlog_total,
    output logic               book_full,
    output logic [FIELD_W-1:0] filled_amount
);

    lobm_cmd_t    cmd;
    lobm_status_t status;

    lobm_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    lobm_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .func          (func),
        .price         (price),
        .amount_in     (amount_in),
        .status        (status),
        .backlog_total (backlog_total),
        .book_full     (book_full),
        .filled_amount (filled_amount)
    );

endmodule

>>> design/lobm_ctrl.sv
// Controller state machine that sequences matching, removal and appending.
module lobm_ctrl
    import lobm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  lobm_status_t status,
    output lobm_cmd_t    cmd,
    output logic         busy,
    output logic         done
);

    lobm_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        done       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.rest_zero || status.opp_empty)
                    state_next = ST_TOTAL;
                else
                    state_next = ST_SCAN_START;
            end
            ST_SCAN_START:
            begin
                cmd.scan_start = 1'b1;
                state_next     = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_done)
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (!status.limit_ok)
                    state_next = ST_TOTAL;
                else
                begin
                    cmd.take = 1'b1;
                    if (status.partial)
                        state_next = ST_TOTAL;
                    else
                        state_next = ST_LAST_WAIT;
                end
            end
            ST_LAST_WAIT:
            begin
                state_next = ST_MOVE;
            end
            ST_MOVE:
            begin
                cmd.move   = 1'b1;
                state_next = ST_CHECK;
            end
            ST_TOTAL:
            begin
                cmd.total  = 1'b1;
                state_next = ST_APPEND;
            end
            ST_APPEND:
            begin
                cmd.append = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                done       = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> design/lobm_dp.sv
// Datapath: both books in memory, counts, best-entry scan and running total.
module lobm_dp
    import lobm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  lobm_cmd_t          cmd,
    input  logic               func,
    input  logic [FIELD_W-1:0] price,
    input  logic [FIELD_W-1:0] amount_in,
    output lobm_status_t       status,
    output logic [FIELD_W-1:0] backlog_total,
    output logic               book_full,
    output logic [FIELD_W-1:0] filled_amount
);

    logic [ENTRY_W-1:0] buy_mem  [BOOK_DEPTH];
    logic [ENTRY_W-1:0] sell_mem [BOOK_DEPTH];

    logic [CNT_W-1:0]   buy_cnt_reg, sell_cnt_reg;
    logic [FIELD_W-1:0] total_reg;
    logic [CNT_W-1:0]   scan_idx_reg;
    logic               rvalid_reg;
    logic [ADDR_W-1:0]  ridx_reg;
    logic               full_reg;

    logic               side_reg;
    logic [FIELD_W-1:0] price_reg, rest_reg, filled_reg;
    logic [ADDR_W-1:0]  best_idx_reg;
    logic [FIELD_W-1:0] best_price_reg, best_amt_reg;
    logic [ENTRY_W-1:0] rd_buy_reg, rd_sell_reg;
    logic [ADDR_W-1:0]  rd_addr;
    logic               rd_en;

    logic [CNT_W-1:0]   opp_cnt, own_cnt, opp_cnt_dec;
    logic [ENTRY_W-1:0] rd_opp;
    logic [FIELD_W-1:0] rd_price, rd_amt;
    logic               better;
    logic               own_full;
    logic [FIELD_W:0]   fmod, total_sub, rmod, total_add;
    logic [FIELD_W-1:0] total_after_fill, total_after_rest;
    logic               wr_en, wr_sell;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic               do_append;

    assign opp_cnt     = (side_reg == SIDE_SELL) ? buy_cnt_reg : sell_cnt_reg;
    assign own_cnt     = (side_reg == SIDE_SELL) ? sell_cnt_reg : buy_cnt_reg;
    assign opp_cnt_dec = opp_cnt - 1'b1;
    assign own_full    = (own_cnt == CNT_W'(BOOK_DEPTH));
    assign rd_opp      = (side_reg == SIDE_SELL) ? rd_buy_reg : rd_sell_reg;
    assign rd_price    = rd_opp[ENTRY_W-1:FIELD_W];
    assign rd_amt      = rd_opp[FIELD_W-1:0];
    // Opposite of a sell is the buy book, served highest first.
    assign better      = (side_reg == SIDE_SELL) ? (rd_price > best_price_reg)
                                                 : (rd_price < best_price_reg);

    assign status.scan_done = (scan_idx_reg == opp_cnt) && !rvalid_reg;
    assign status.limit_ok  = (side_reg == SIDE_SELL) ? (best_price_reg >= price_reg)
                                                      : (best_price_reg <= price_reg);
    assign status.partial   = (best_amt_reg > rest_reg);
    assign status.rest_zero = (rest_reg == '0);
    assign status.opp_empty = (opp_cnt == '0);

    // Running total: remove the filled part, then add the rest that joins its book.
    assign fmod      = ({1'b0, filled_reg} >= {1'b0, BACKLOG_MOD})
                       ? ({1'b0, filled_reg} - {1'b0, BACKLOG_MOD}) : {1'b0, filled_reg};
    assign total_sub = ({1'b0, total_reg} >= fmod)
                       ? ({1'b0, total_reg} - fmod)
                       : ({1'b0, total_reg} + {1'b0, BACKLOG_MOD} - fmod);
    assign total_after_fill = total_sub[FIELD_W-1:0];
    assign rmod      = ({1'b0, rest_reg} >= {1'b0, BACKLOG_MOD})
                       ? ({1'b0, rest_reg} - {1'b0, BACKLOG_MOD}) : {1'b0, rest_reg};
    assign total_add = {1'b0, total_reg} + rmod;
    assign total_after_rest = (total_add >= {1'b0, BACKLOG_MOD})
                              ? FIELD_W'(total_add - {1'b0, BACKLOG_MOD})
                              : total_add[FIELD_W-1:0];

    assign do_append = cmd.append && (rest_reg != '0) && !own_full;

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = scan_idx_reg[ADDR_W-1:0];
        if (cmd.scan && (scan_idx_reg != opp_cnt))
            rd_en = 1'b1;
        else if (cmd.take && !status.partial)
        begin
            rd_en   = 1'b1;
            rd_addr = opp_cnt_dec[ADDR_W-1:0];
        end
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_sell = !side_reg;
        wr_addr = best_idx_reg;
        wr_data = {best_price_reg, best_amt_reg - rest_reg};
        if (cmd.take && status.partial)
            wr_en = 1'b1;
        else if (cmd.move)
        begin
            wr_en   = 1'b1;
            wr_data = rd_opp;
        end
        else if (do_append)
        begin
            wr_en   = 1'b1;
            wr_sell = side_reg;
            wr_addr = own_cnt[ADDR_W-1:0];
            wr_data = {price_reg, rest_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && wr_sell)
            sell_mem[wr_addr] <= wr_data;
        if (wr_en && !wr_sell)
            buy_mem[wr_addr] <= wr_data;
        if (rd_en)
        begin
            rd_buy_reg  <= buy_mem[rd_addr];
            rd_sell_reg <= sell_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buy_cnt_reg  <= '0;
            sell_cnt_reg <= '0;
            total_reg    <= '0;
            scan_idx_reg <= '0;
            rvalid_reg   <= 1'b0;
            full_reg     <= 1'b0;
        end
        else
        begin
            rvalid_reg <= cmd.scan && (scan_idx_reg != opp_cnt);
            if (cmd.load)
                full_reg <= 1'b0;
            if (cmd.scan_start)
                scan_idx_reg <= '0;
            else if (cmd.scan && (scan_idx_reg != opp_cnt))
                scan_idx_reg <= scan_idx_reg + 1'b1;
            if (cmd.take && !status.partial)
            begin
                if (side_reg == SIDE_SELL)
                    buy_cnt_reg <= opp_cnt_dec;
                else
                    sell_cnt_reg <= opp_cnt_dec;
            end
            if (cmd.total)
                total_reg <= total_after_fill;
            if (cmd.append && (rest_reg != '0))
            begin
                if (own_full)
                    full_reg <= 1'b1;
                else
                begin
                    total_reg <= total_after_rest;
                    if (side_reg == SIDE_SELL)
                        sell_cnt_reg <= sell_cnt_reg + 1'b1;
                    else
                        buy_cnt_reg <= buy_cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            side_reg   <= func;
            price_reg  <= price;
            rest_reg   <= amount_in;
            filled_reg <= '0;
        end
        if (cmd.scan)
            ridx_reg <= scan_idx_reg[ADDR_W-1:0];
        if (rvalid_reg && ((ridx_reg == '0) || better))
        begin
            best_idx_reg   <= ridx_reg;
            best_price_reg <= rd_price;
            best_amt_reg   <= rd_amt;
        end
        if (cmd.take)
        begin
            if (status.partial)
            begin
                filled_reg <= filled_reg + rest_reg;
                rest_reg   <= '0;
            end
            else
            begin
                filled_reg <= filled_reg + best_amt_reg;
                rest_reg   <= rest_reg - best_amt_reg;
            end
        end
    end

    assign backlog_total = total_reg;
    assign book_full     = full_reg;
    assign filled_amount = filled_reg;

endmodule

>>> design/lobm_checker.sv
// Port-level checks of the order book matcher and their binding.
module lobm_checker
    import lobm_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic [FIELD_W-1:0] backlog_total
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("transfer accepted but block not busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_done_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result outside an accepted transfer");

    a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (backlog_total < BACKLOG_MOD))
        else $error("backlog total out of range");

    a_idle_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("block still busy after result");

endmodule

bind limit_order_book_matcher lobm_checker u_lobm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .backlog_total (backlog_total)
);
